// ----- hdl/s2h_pkg.sv -----
package s2h_pkg;

    localparam int SINGLE_W = 32;
    localparam int HALF_W   = 16;
    localparam int EXP_W    = 8;
    localparam int FRAC_W   = 23;
    localparam int SIG_W    = 24;
    localparam int HEXP_W   = 5;
    localparam int HFRAC_W  = 10;
    localparam int SH_W     = 5;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [EXP_W-1:0] EXP_ZERO     = 8'h00;
    // rebias 127 -> 15
    localparam logic [EXP_W-1:0] BIAS_ADJ     = 8'd112;
    // rebiased exponent of 31 or more
    localparam logic [EXP_W-1:0] OVF_EXP      = 8'd143;
    // shift of 24 or less keeps something
    localparam logic [EXP_W-1:0] SUB_MIN_EXP  = 8'd102;
    // shift = 14 - rebiased exponent
    localparam logic [EXP_W-1:0] SUB_SH_BASE  = 8'd126;

    localparam logic [HALF_W-1:0] INF16     = 16'h7C00;
    localparam logic [HALF_W-1:0] NAN_QUIET = 16'h0200;

    // stage 1 -> stage 2
    typedef struct packed {
        logic                special;
        logic [HALF_W-1:0]   special_val;
        logic                sub;
        logic                sign;
        logic [HEXP_W-1:0]   hexp;
        logic [SH_W-1:0]     sh;
        logic [SIG_W-1:0]    sig;
    } s2h_cls_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic [HALF_W-1:0]   base;
        logic                rnd;
    } s2h_rnd_t;

endpackage

// ----- hdl/s2h_classify.sv -----
module s2h_classify
    import s2h_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [SINGLE_W-1:0] single_bits,
    output logic                out_valid,
    output s2h_cls_t            cls
);

    logic                valid_reg;
    s2h_cls_t            cls_reg;
    s2h_cls_t            cls_next;
    logic                sign;
    logic [EXP_W-1:0]    expo;
    logic [FRAC_W-1:0]   frac;
    logic [EXP_W-1:0]    hexp_full;
    logic [EXP_W-1:0]    sh_full;
    logic [HALF_W-1:0]   nan_val;

    assign sign = single_bits[SINGLE_W-1];
    assign expo = single_bits[SINGLE_W-2 -: EXP_W];
    assign frac = single_bits[FRAC_W-1:0];

    assign hexp_full = expo - BIAS_ADJ;
    assign sh_full   = SUB_SH_BASE - expo;
    assign nan_val   = (frac[FRAC_W-1 -: HFRAC_W] == '0) ? (INF16 | NAN_QUIET)
                     : (INF16 | {{(HALF_W-HFRAC_W){1'b0}}, frac[FRAC_W-1 -: HFRAC_W]});

    always_comb
    begin
        cls_next.sign        = sign;
        cls_next.hexp        = hexp_full[HEXP_W-1:0];
        cls_next.sh          = sh_full[SH_W-1:0];
        cls_next.sig         = {1'b1, frac};
        cls_next.sub         = (expo >= SUB_MIN_EXP) && (expo <= BIAS_ADJ);
        cls_next.special     = 1'b0;
        cls_next.special_val = {sign, {(HALF_W-1){1'b0}}};
        if (expo == EXP_ALL_ONES)
        begin
            cls_next.special     = 1'b1;
            cls_next.special_val = (frac == '0) ? ({sign, {(HALF_W-1){1'b0}}} | INF16)
                                                : nan_val;
        end
        else if (expo >= OVF_EXP)
        begin
            cls_next.special     = 1'b1;
            cls_next.special_val = {sign, {(HALF_W-1){1'b0}}} | INF16;
        end
        else if ((expo == EXP_ZERO) || (expo < SUB_MIN_EXP))
        begin
            // zeros, single subnormals and deep underflow
            cls_next.special     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
    end

    assign out_valid = valid_reg;
    assign cls       = cls_reg;

endmodule

// ----- hdl/s2h_align.sv -----
module s2h_align
    import s2h_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  s2h_cls_t  cls,
    output logic      out_valid,
    output s2h_rnd_t  rnd
);

    logic              valid_reg;
    s2h_rnd_t          rnd_reg;
    s2h_rnd_t          rnd_next;
    logic [SIG_W-1:0]  shifted;
    logic [SH_W-1:0]   rsel;

    assign shifted = cls.sig >> cls.sh;
    assign rsel    = cls.sh - SH_W'(1);

    always_comb
    begin
        if (cls.special)
        begin
            rnd_next.base = cls.special_val;
            rnd_next.rnd  = 1'b0;
        end
        else if (cls.sub)
        begin
            // hidden bit shifted into the fraction field
            rnd_next.base = {cls.sign, {HEXP_W{1'b0}}, shifted[HFRAC_W-1:0]};
            rnd_next.rnd  = cls.sig[rsel];
        end
        else
        begin
            rnd_next.base = {cls.sign, cls.hexp, cls.sig[FRAC_W-1 -: HFRAC_W]};
            rnd_next.rnd  = cls.sig[FRAC_W-HFRAC_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
    end

    assign out_valid = valid_reg;
    assign rnd       = rnd_reg;

endmodule

// ----- hdl/s2h_round.sv -----
module s2h_round
    import s2h_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  s2h_rnd_t          rnd,
    output logic              out_valid,
    output logic [HALF_W-1:0] half_bits
);

    logic              valid_reg;
    logic [HALF_W-1:0] half_reg;
    logic [HALF_W-1:0] half_next;

    // carry may run into the exponent, up to infinity
    assign half_next = rnd.base + {{(HALF_W-1){1'b0}}, rnd.rnd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        half_reg <= half_next;
    end

    assign out_valid = valid_reg;
    assign half_bits = half_reg;

endmodule

// ----- hdl/single_to_half_float.sv -----
// binary32 to binary16 converter, three register stages.
// done is raised once the word taken with start has passed the classify, align and round registers.
// Throughput: one word per cycle; busy is tied low, every start is taken.
// Stages: classify, align and shift, round and carry.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset (rst_n low, asynchronous) clears the stage valid bits; data is not reset.
module single_to_half_float
    import s2h_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SINGLE_W-1:0] single_bits,
    output logic                done,
    output logic [HALF_W-1:0]   half_bits
);

    logic      accept;
    logic      s1_valid;
    logic      s2_valid;
    s2h_cls_t  s1_cls;
    s2h_rnd_t  s2_rnd;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    s2h_classify u_classify
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .single_bits (single_bits),
        .out_valid   (s1_valid),
        .cls         (s1_cls)
    );

    s2h_align u_align
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .cls       (s1_cls),
        .out_valid (s2_valid),
        .rnd       (s2_rnd)
    );

    s2h_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .rnd       (s2_rnd),
        .out_valid (done),
        .half_bits (half_bits)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("word lost in pipeline");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a word");

    a_nan_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(single_bits[30:23], 3) == EXP_ALL_ONES
              && $past(single_bits[22:0], 3) != '0)
        |-> (half_bits[14:10] == 5'h1F && half_bits[9:0] != '0))
        else $error("NaN not kept as NaN");

    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(single_bits[30:23], 3) != EXP_ALL_ONES)
        |-> (half_bits[15] == $past(single_bits[31], 3)))
        else $error("sign not carried");

endmodule
